// File: rtl/core/rvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS vector normalizer package
// Shared constants, state encoding and a helper function.
// ----------------------------------------------------------------------------
package rvn_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam logic [31:0] EPSILON_RESET = 32'd4295;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ERROR     = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_DIV1,
        S_MADD,
        S_DIV2,
        S_SQRT,
        S_MUL1,
        S_MUL2,
        S_RND,
        S_OUT
    } state_t;

    function automatic logic [16:0] mag16(input logic [15:0] v);
        mag16 = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/rms_vector_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Load beat: idle and accumulate; the closing beat adds 64 divide, 1 add, 73 divide
// and 32 square root steps of the shared iterative unit; the second divide and root
// are skipped if mean plus epsilon is at most 256. Emit beat: read, two multiplies,
// rounding, output register; on error only the last. One beat is in work at a time;
// a finished result may wait in the output register while the next beat is taken.
// Reset clears all control state, sets the default epsilon, keeps element memory.
// ----------------------------------------------------------------------------
// RMS vector normalizer
// Stores a vector, computes its inverse RMS with a shared divide and square
// root sequencer, and returns weighted normalized elements.
// ----------------------------------------------------------------------------
module rms_vector_normalizer
    import rvn_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [15:0] x_value,
    input  wire logic [15:0] weight_value,
    input  wire logic        load_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      y_value,
    output logic             out_last,
    output logic [1:0]       status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

    logic [15:0] mem [MAX_ELEMENTS];
    logic [15:0] rd_data_reg;

    state_t state_reg, state_next;
    logic [31:0] eps_reg;
    logic [47:0] sum_reg, sum_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [31:0] inv_reg, inv_next;
    logic vready_reg, vready_next;
    logic trunc_reg, trunc_next;
    logic open_reg, open_next;
    logic [30:0] sq_reg, sq_next;
    logic add_reg, add_next;
    logic last_reg, last_next;
    logic [6:0] iter_reg, iter_next;
    logic [65:0] rem_reg, rem_next;
    logic [63:0] div_reg, div_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] root_reg, root_next;
    logic [63:0] bit_reg, bit_next;
    logic [16:0] mw_reg, mw_next;
    logic wneg_reg, wneg_next;
    logic [63:0] prod_reg, prod_next;
    logic [15:0] res_y_reg, res_y_next;
    logic res_last_reg, res_last_next;
    logic [1:0] res_st_reg, res_st_next;
    logic ov_reg, ov_next;
    logic [15:0] oy_reg, oy_next;
    logic olast_reg, olast_next;
    logic [1:0] ost_reg, ost_next;

    logic accept;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [65:0] rem_sh;
    logic in_bit;
    logic q_bit;
    logic [63:0] m_val;
    logic [63:0] sq_try;
    logic [16:0] mx_mem;
    logic [65:0] prod_full;
    logic [63:0] rnd_sum;
    logic [31:0] rnd_r;
    logic neg_x;
    logic [CW-1:0] eff_count;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign y_value   = oy_reg;
    assign out_last  = olast_reg;
    assign status    = ost_reg;

    assign eff_count = open_reg ? count_reg : '0;
    assign wr_en     = accept && (op == OP_LOAD) && (eff_count < MAX_C);
    assign wr_addr   = eff_count[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= x_value;
        end
        rd_data_reg <= mem[ptr_reg[AW-1:0]];
    end

    assign in_bit    = (state_reg == S_DIV1) ? quo_reg[63] : (iter_reg == 7'd72);
    assign rem_sh    = {rem_reg[64:0], in_bit};
    assign q_bit     = (rem_sh >= {2'b00, div_reg});
    assign m_val     = quo_reg + {32'd0, eps_reg};
    assign sq_try    = root_reg + bit_reg;
    assign mx_mem    = mag16(rd_data_reg);
    assign neg_x     = rd_data_reg[15];
    assign prod_full = prod_reg[48:0] * mw_reg;
    assign rnd_sum   = prod_reg + 64'h8000_0000;
    assign rnd_r     = rnd_sum[63:32];

    always_comb
    begin
        state_next    = state_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        inv_next      = inv_reg;
        vready_next   = vready_reg;
        trunc_next    = trunc_reg;
        open_next     = open_reg;
        sq_next       = sq_reg;
        add_next      = add_reg;
        last_next     = last_reg;
        iter_next     = iter_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        quo_next      = quo_reg;
        root_next     = root_reg;
        bit_next      = bit_reg;
        mw_next       = mw_reg;
        wneg_next     = wneg_reg;
        prod_next     = prod_reg;
        res_y_next    = res_y_reg;
        res_last_next = res_last_reg;
        res_st_next   = res_st_reg;
        ov_next       = ov_reg;
        oy_next       = oy_reg;
        olast_next    = olast_reg;
        ost_next      = ost_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_LOAD)
                    begin
                        if (!open_reg)
                        begin
                            sum_next    = '0;
                            ptr_next    = '0;
                            trunc_next  = 1'b0;
                            vready_next = 1'b0;
                            open_next   = 1'b1;
                        end
                        sq_next   = 31'((mag16(x_value) * mag16(x_value)));
                        add_next  = wr_en;
                        last_next = load_last;
                        if (wr_en)
                        begin
                            count_next = eff_count + 1'b1;
                        end
                        else
                        begin
                            count_next = eff_count;
                            trunc_next = 1'b1;
                        end
                        if (load_last)
                        begin
                            open_next = 1'b0;
                            ptr_next  = '0;
                        end
                        state_next = S_ACC;
                    end
                    else if (!vready_reg || (ptr_reg >= count_reg))
                    begin
                        res_y_next    = '0;
                        res_last_next = 1'b0;
                        res_st_next   = STATUS_ERROR;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        mw_next       = mag16(weight_value);
                        wneg_next     = weight_value[15];
                        res_last_next = (ptr_reg + 1'b1 == count_reg);
                        res_st_next   = trunc_reg ? STATUS_TRUNCATED : STATUS_OK;
                        ptr_next      = ptr_reg + 1'b1;
                        state_next    = S_MUL1;
                    end
                end
            end
            S_ACC:
            begin
                if (add_reg)
                begin
                    sum_next = sum_reg + {17'd0, sq_reg};
                end
                if (last_reg)
                begin
                    quo_next   = {sum_next, 16'd0};
                    rem_next   = '0;
                    div_next   = (count_reg == '0) ? 64'd1 : 64'(count_reg);
                    iter_next  = 7'd63;
                    state_next = S_DIV1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV1, S_DIV2:
            begin
                rem_next = q_bit ? (rem_sh - {2'b00, div_reg}) : rem_sh;
                quo_next = {quo_reg[62:0], q_bit};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    if (state_reg == S_DIV1)
                    begin
                        state_next = S_MADD;
                    end
                    else
                    begin
                        root_next  = '0;
                        bit_next   = 64'd1 << 62;
                        iter_next  = 7'd31;
                        state_next = S_SQRT;
                    end
                end
            end
            S_MADD:
            begin
                if (m_val <= 64'd256)
                begin
                    inv_next    = 32'hFFFF_FFFF;
                    vready_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    div_next   = m_val;
                    rem_next   = '0;
                    quo_next   = '0;
                    iter_next  = 7'd72;
                    state_next = S_DIV2;
                end
            end
            S_SQRT:
            begin
                if (quo_reg >= sq_try)
                begin
                    quo_next  = quo_reg - sq_try;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    inv_next    = root_next[31:0];
                    vready_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_MUL1:
            begin
                prod_next  = 64'(mx_mem * inv_reg);
                wneg_next  = wneg_reg ^ neg_x;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                prod_next  = prod_full[63:0];
                state_next = S_RND;
            end
            S_RND:
            begin
                if (wneg_reg)
                begin
                    res_y_next = (rnd_r > 32'd32768) ? 16'h8000 :
                                 16'(32'h1_0000 - rnd_r);
                end
                else
                begin
                    res_y_next = (rnd_r > 32'd32767) ? 16'h7FFF : rnd_r[15:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    oy_next    = res_y_reg;
                    olast_next = res_last_reg;
                    ost_next   = res_st_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            eps_reg    <= EPSILON_RESET;
            sum_reg    <= '0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            inv_reg    <= '0;
            vready_reg <= 1'b0;
            trunc_reg  <= 1'b0;
            open_reg   <= 1'b0;
            add_reg    <= 1'b0;
            last_reg   <= 1'b0;
            iter_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                eps_reg <= cfg_data;
            end
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            inv_reg    <= inv_next;
            vready_reg <= vready_next;
            trunc_reg  <= trunc_next;
            open_reg   <= open_next;
            add_reg    <= add_next;
            last_reg   <= last_next;
            iter_reg   <= iter_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg       <= sq_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        quo_reg      <= quo_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        mw_reg       <= mw_next;
        wneg_reg     <= wneg_next;
        prod_reg     <= prod_next;
        res_y_reg    <= res_y_next;
        res_last_reg <= res_last_next;
        res_st_reg   <= res_st_next;
        oy_reg       <= oy_next;
        olast_reg    <= olast_next;
        ost_reg      <= ost_next;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE))
        else $error("ready outside idle");

    a_div_to_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV2 && iter_reg == '0) |=> (state_reg == S_SQRT))
        else $error("divide did not hand over to square root");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("element count beyond capacity");

    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ost_reg == STATUS_ERROR) |-> (oy_reg == '0 && !olast_reg))
        else $error("error beat carries data");

endmodule
`default_nettype wire
